[rtl/bsalu_pkg.sv]
// ---------------------------------------------------------------------------
// bsalu_pkg
// Shared types and instruction codes for the bit-slice ALU.
// ---------------------------------------------------------------------------
`default_nettype none

package bsalu_pkg;

    localparam int FIELD_BITS = 4;

    typedef logic [2:0] t_code;
    typedef logic [1:0] t_link;

    // operand pair (R, S)
    localparam t_code SRC_AQ = 3'd0;
    localparam t_code SRC_AB = 3'd1;
    localparam t_code SRC_ZQ = 3'd2;
    localparam t_code SRC_ZB = 3'd3;
    localparam t_code SRC_ZA = 3'd4;
    localparam t_code SRC_DA = 3'd5;
    localparam t_code SRC_DQ = 3'd6;
    localparam t_code SRC_DZ = 3'd7;

    // ALU function
    localparam t_code FN_ADD   = 3'd0;
    localparam t_code FN_SUBR  = 3'd1;
    localparam t_code FN_SUBS  = 3'd2;
    localparam t_code FN_OR    = 3'd3;
    localparam t_code FN_AND   = 3'd4;
    localparam t_code FN_NOTRS = 3'd5;
    localparam t_code FN_XOR   = 3'd6;
    localparam t_code FN_XNOR  = 3'd7;

    // destination
    localparam t_code DST_QREG  = 3'd0;
    localparam t_code DST_NOP   = 3'd1;
    localparam t_code DST_RAMA  = 3'd2;
    localparam t_code DST_RAMF  = 3'd3;
    localparam t_code DST_RAMQD = 3'd4;
    localparam t_code DST_RAMD  = 3'd5;
    localparam t_code DST_RAMQU = 3'd6;
    localparam t_code DST_RAMU  = 3'd7;

    // shift link mode
    localparam t_link LINK_ZERO = 2'd0;
    localparam t_link LINK_ROT  = 2'd1;
    localparam t_link LINK_XROT = 2'd2;
    localparam t_link LINK_DBL  = 2'd3;

    typedef struct packed {
        t_code                 src;
        t_code                 func;
        t_code                 dest;
        logic [FIELD_BITS-1:0] data;
        logic                  carry;
        logic                  clear;
    } t_instr;

endpackage

`default_nettype wire

[rtl/bsalu_ram.sv]
// ---------------------------------------------------------------------------
// bsalu_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module bsalu_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

[rtl/bit_slice_alu_with_register_file_top.sv]
// ---------------------------------------------------------------------------
// bit_slice_alu_with_register_file_top
// Bit-slice ALU with register file, Q register and shift link logic.
// ---------------------------------------------------------------------------
// Takes one microinstruction per clock. An accepted item issues its A and B
// register file reads on the accept edge and is held in the s1 register,
// where F is computed; on commit it writes back register B and Q and loads
// the output register. A write from one item is forwarded to the reads of
// the item right behind it. A clear item gives no result and drops the
// per-entry valid bits, so cleared entries read as zero with no sweep. The
// input stalls only while the output register holds a result that is itself
// stalled.
`default_nettype none

module bit_slice_alu_with_register_file_top #(
    parameter int WORD_BITS = 4,
    parameter int REG_COUNT = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_wr_en,
    input  wire bsalu_pkg::t_link               i_cfg_wr_data,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire bsalu_pkg::t_code               i_src_select,
    input  wire bsalu_pkg::t_code               i_func,
    input  wire bsalu_pkg::t_code               i_dest_select,
    input  wire logic [bsalu_pkg::FIELD_BITS-1:0] i_addr_a,
    input  wire logic [bsalu_pkg::FIELD_BITS-1:0] i_addr_b,
    input  wire logic [bsalu_pkg::FIELD_BITS-1:0] i_data_in,
    input  wire logic                           i_carry_in,
    input  wire logic                           i_clear,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic [bsalu_pkg::FIELD_BITS-1:0]    o_y_out,
    output logic                                o_zero,
    output logic                                o_sign,
    output logic                                o_carry_out,
    output logic                                o_overflow,
    output logic                                o_ram_low_bit,
    output logic                                o_ram_high_bit,
    output logic                                o_q_low_bit,
    output logic                                o_q_high_bit
);

    import bsalu_pkg::*;

    localparam int AW = $clog2(REG_COUNT);
    localparam int W  = WORD_BITS;
    localparam logic [FIELD_BITS:0] ModN = (REG_COUNT >= (1 << FIELD_BITS)) ?
        (FIELD_BITS+1)'(1 << FIELD_BITS) : (FIELD_BITS+1)'(REG_COUNT);

    function automatic logic [AW-1:0] f_wrap(input logic [FIELD_BITS-1:0] a);
        logic [FIELD_BITS:0] v;
        v = {1'b0, a};
        for (int k = 0; k < 8; k++) begin
            if (v >= ModN) begin
                v = v - ModN;
            end
        end
        return AW'(v);
    endfunction

    // control
    logic            r_s1_v;
    t_instr          r_s1;
    logic [AW-1:0]   r_s1_ia;
    logic [AW-1:0]   r_s1_ib;
    logic            r_fwd_v;
    logic [AW-1:0]   r_fwd_addr;
    logic [W-1:0]    r_fwd_data;
    logic [REG_COUNT-1:0] r_vld;
    logic [W-1:0]    r_q;
    t_link           r_link_mode;

    logic            in_accept;
    logic            commit;
    logic            wr_en;
    logic [W-1:0]    wr_data;
    logic [AW-1:0]   rd_ia;
    logic [AW-1:0]   rd_ib;
    logic [W-1:0]    ram_a;
    logic [W-1:0]    ram_b;

    // datapath
    logic [W-1:0]    ra, rb, r, s, ra_x, sa_x, f, y, nr, nq;
    logic [W:0]      sum;
    logic            cout, cmsb;
    logic            down, withq, rlink, qlink, is_shift;

    assign rd_ia     = f_wrap(i_addr_a);
    assign rd_ib     = f_wrap(i_addr_b);
    assign commit    = r_s1_v && (r_s1.clear || !o_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_v && !commit;
    assign in_accept = i_in_valid && !o_in_stall;

    bsalu_ram #(.WIDTH(W), .DEPTH(REG_COUNT)) u_ram_a (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_s1_ib),
        .i_wr_data (wr_data),
        .i_rd_en   (in_accept),
        .i_rd_addr (rd_ia),
        .o_rd_data (ram_a)
    );

    bsalu_ram #(.WIDTH(W), .DEPTH(REG_COUNT)) u_ram_b (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_s1_ib),
        .i_wr_data (wr_data),
        .i_rd_en   (in_accept),
        .i_rd_addr (rd_ib),
        .o_rd_data (ram_b)
    );

    always_comb begin
        if (r_fwd_v && r_fwd_addr == r_s1_ia) begin
            ra = r_fwd_data;
        end else begin
            ra = r_vld[r_s1_ia] ? ram_a : '0;
        end
        if (r_fwd_v && r_fwd_addr == r_s1_ib) begin
            rb = r_fwd_data;
        end else begin
            rb = r_vld[r_s1_ib] ? ram_b : '0;
        end

        unique case (r_s1.src)
            SRC_AQ:  begin r = ra; s = r_q; end
            SRC_AB:  begin r = ra; s = rb;  end
            SRC_ZQ:  begin r = '0; s = r_q; end
            SRC_ZB:  begin r = '0; s = rb;  end
            SRC_ZA:  begin r = '0; s = ra;  end
            SRC_DA:  begin r = W'(r_s1.data); s = ra;  end
            SRC_DQ:  begin r = W'(r_s1.data); s = r_q; end
            default: begin r = W'(r_s1.data); s = '0;  end
        endcase

        ra_x = (r_s1.func == FN_SUBR) ? ~r : r;
        sa_x = (r_s1.func == FN_SUBS) ? ~s : s;
        sum  = {1'b0, ra_x} + {1'b0, sa_x} + (W+1)'(r_s1.carry);
        cout = sum[W];
        cmsb = ra_x[W-1] ^ sa_x[W-1] ^ sum[W-1];

        unique case (r_s1.func)
            FN_ADD, FN_SUBR, FN_SUBS: f = sum[W-1:0];
            FN_OR:    f = r | s;
            FN_AND:   f = r & s;
            FN_NOTRS: f = ~r & s;
            FN_XOR:   f = r ^ s;
            default:  f = ~(r ^ s);
        endcase

        down     = (r_s1.dest == DST_RAMQD) || (r_s1.dest == DST_RAMD);
        withq    = (r_s1.dest == DST_RAMQD) || (r_s1.dest == DST_RAMQU);
        is_shift = r_s1.dest[2];

        rlink = 1'b0;
        qlink = 1'b0;
        unique case (r_link_mode)
            LINK_ROT: begin
                rlink = down ? f[0]   : f[W-1];
                qlink = down ? r_q[0] : r_q[W-1];
            end
            LINK_XROT: begin
                rlink = down ? r_q[0] : r_q[W-1];
                qlink = down ? f[0]   : f[W-1];
            end
            LINK_DBL: begin
                if (down) begin
                    qlink = f[0];
                end else begin
                    rlink = r_q[W-1];
                end
            end
            default: ;
        endcase

        if (down) begin
            nr = {rlink, f[W-1:1]};
            nq = {qlink, r_q[W-1:1]};
        end else begin
            nr = {f[W-2:0], rlink};
            nq = {r_q[W-2:0], qlink};
        end

        y       = (r_s1.dest == DST_RAMA) ? ra : f;
        wr_en   = commit && !r_s1.clear &&
                  (r_s1.dest != DST_QREG) && (r_s1.dest != DST_NOP);
        wr_data = is_shift ? nr : f;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v      <= 1'b0;
            r_fwd_v     <= 1'b0;
            r_vld       <= '0;
            r_q         <= '0;
            r_link_mode <= LINK_ZERO;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_link_mode <= i_cfg_wr_data;
            end

            if (in_accept) begin
                r_s1_v     <= 1'b1;
                r_fwd_v    <= wr_en;
                r_fwd_addr <= r_s1_ib;
                r_fwd_data <= wr_data;
            end else if (commit) begin
                r_s1_v <= 1'b0;
            end

            if (commit && r_s1.clear) begin
                r_vld <= '0;
                r_q   <= '0;
            end else if (commit) begin
                if (wr_en) begin
                    r_vld[r_s1_ib] <= 1'b1;
                end
                if (r_s1.dest == DST_QREG) begin
                    r_q <= f;
                end else if (is_shift && withq) begin
                    r_q <= nq;
                end
            end

            if (commit && !r_s1.clear) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1.src   <= i_src_select;
            r_s1.func  <= i_func;
            r_s1.dest  <= i_dest_select;
            r_s1.data  <= (W < FIELD_BITS) ?
                          FIELD_BITS'(W'(i_data_in)) : i_data_in;
            r_s1.carry <= i_carry_in;
            r_s1.clear <= i_clear;
            r_s1_ia    <= rd_ia;
            r_s1_ib    <= rd_ib;
        end
        if (commit && !r_s1.clear) begin
            o_y_out        <= FIELD_BITS'(y);
            o_zero         <= (f == '0);
            o_sign         <= f[W-1];
            o_carry_out    <= cout;
            o_overflow     <= cmsb ^ cout;
            o_ram_low_bit  <= is_shift & nr[0];
            o_ram_high_bit <= is_shift & nr[W-1];
            o_q_low_bit    <= is_shift & withq & nq[0];
            o_q_high_bit   <= is_shift & withq & nq[W-1];
        end
    end

endmodule

`default_nettype wire

[rtl/bsalu_checker.sv]
// ---------------------------------------------------------------------------
// bsalu_checker
// Port-level checks for the bit-slice ALU, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module bsalu_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_in_stall,
    input wire logic       o_out_valid,
    input wire logic       i_out_stall,
    input wire logic [3:0] o_y_out,
    input wire logic       o_zero,
    input wire logic       o_sign
);

    // back-pressure only when the output register is full and held
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a held result");

    // zero result cannot be negative
    a_zero_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_zero) |-> !o_sign)
        else $error("zero and sign flags both set");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result present after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_y_out)))
        else $error("stalled result changed");

endmodule

bind bit_slice_alu_with_register_file_top bsalu_checker u_bsalu_checker (.*);

`default_nettype wire

[bench/bit_slice_alu_checker.sv]
// ---------------------------------------------------------------------------
// bit_slice_alu_checker
// Watches the item and result channels of the bit-slice ALU, keeps its own
// copy of the register file, Q register and shift link mode, works out the
// result of every accepted item and compares results field by field in order.
// ---------------------------------------------------------------------------
module bit_slice_alu_checker
    import bsalu_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_wr_en,
    input  wire t_link                 i_cfg_wr_data,
    input  wire logic                  i_in_valid,
    input  wire logic                  i_in_stall,
    input  wire t_code                 i_src_select,
    input  wire t_code                 i_func,
    input  wire t_code                 i_dest_select,
    input  wire logic [FIELD_BITS-1:0] i_addr_a,
    input  wire logic [FIELD_BITS-1:0] i_addr_b,
    input  wire logic [FIELD_BITS-1:0] i_data_in,
    input  wire logic                  i_carry_in,
    input  wire logic                  i_clear,
    input  wire logic                  i_out_valid,
    input  wire logic                  i_out_stall,
    input  wire logic [FIELD_BITS-1:0] i_y_out,
    input  wire logic                  i_zero,
    input  wire logic                  i_sign,
    input  wire logic                  i_carry_out,
    input  wire logic                  i_overflow,
    input  wire logic                  i_ram_low_bit,
    input  wire logic                  i_ram_high_bit,
    input  wire logic                  i_q_low_bit,
    input  wire logic                  i_q_high_bit,
    output int                         o_pending,
    output int                         o_error_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WB    = FIELD_BITS;
    localparam int NREGS = 16;

    typedef struct packed {
        logic [WB-1:0] y;
        logic          zero;
        logic          sign;
        logic          carry;
        logic          ovf;
        logic          ram_lo;
        logic          ram_hi;
        logic          q_lo;
        logic          q_hi;
    } t_alu_result;

    logic [WB-1:0] reg_file [NREGS];
    logic [WB-1:0] q_reg;
    t_link         link_mode;
    t_alu_result   expected_results[$];
    int            n_mismatch = 0;

    assign o_error_count = n_mismatch;

    function automatic bit exec_microinstr(
        input  t_code         src,
        input  t_code         fn,
        input  t_code         dst,
        input  logic [WB-1:0] adr_a,
        input  logic [WB-1:0] adr_b,
        input  logic [WB-1:0] d,
        input  logic          c0,
        input  logic          clr,
        output t_alu_result   res
    );
        logic [WB-1:0] ra, rb, q, r, s, ri, si, f, nr, nq;
        logic [WB:0]   sum;
        logic          cmsb, rlink, qlink, down, withq;
        res = '0;
        if (clr) begin
            foreach (reg_file[k]) reg_file[k] = '0;
            q_reg = '0;
            return 1'b0;
        end
        ra = reg_file[adr_a % NREGS];
        rb = reg_file[adr_b % NREGS];
        q  = q_reg;
        case (src)
            SRC_AQ: begin
                r = ra; s = q;
            end
            SRC_AB: begin
                r = ra; s = rb;
            end
            SRC_ZQ: begin
                r = '0; s = q;
            end
            SRC_ZB: begin
                r = '0; s = rb;
            end
            SRC_ZA: begin
                r = '0; s = ra;
            end
            SRC_DA: begin
                r = d; s = ra;
            end
            SRC_DQ: begin
                r = d; s = q;
            end
            default: begin
                r = d; s = '0;
            end
        endcase

        // carry and overflow come from the adder for every function
        ri   = (fn == FN_SUBR) ? ~r : r;
        si   = (fn == FN_SUBS) ? ~s : s;
        sum  = {1'b0, ri} + {1'b0, si} + c0;
        cmsb = ri[WB-1] ^ si[WB-1] ^ sum[WB-1];
        case (fn)
            FN_ADD, FN_SUBR, FN_SUBS: f = sum[WB-1:0];
            FN_OR:    f = r | s;
            FN_AND:   f = r & s;
            FN_NOTRS: f = ~r & s;
            FN_XOR:   f = r ^ s;
            default:  f = ~(r ^ s);
        endcase

        res.y     = f;
        res.zero  = (f == '0);
        res.sign  = f[WB-1];
        res.carry = sum[WB];
        res.ovf   = cmsb ^ sum[WB];
        case (dst)
            DST_QREG: q_reg = f;
            DST_NOP: ;
            DST_RAMA: begin
                res.y = ra;
                reg_file[adr_b % NREGS] = f;
            end
            DST_RAMF: reg_file[adr_b % NREGS] = f;
            default: begin
                down  = (dst == DST_RAMQD) || (dst == DST_RAMD);
                withq = (dst == DST_RAMQD) || (dst == DST_RAMQU);
                rlink = 1'b0;
                qlink = 1'b0;
                case (link_mode)
                    LINK_ROT: begin
                        rlink = down ? f[0] : f[WB-1];
                        qlink = down ? q[0] : q[WB-1];
                    end
                    LINK_XROT: begin
                        rlink = down ? q[0] : q[WB-1];
                        qlink = down ? f[0] : f[WB-1];
                    end
                    LINK_DBL: begin
                        if (down) begin
                            qlink = f[0];
                        end else begin
                            rlink = q[WB-1];
                        end
                    end
                    default: ;
                endcase
                nr = down ? {rlink, f[WB-1:1]} : {f[WB-2:0], rlink};
                nq = down ? {qlink, q[WB-1:1]} : {q[WB-2:0], qlink};
                reg_file[adr_b % NREGS] = nr;
                res.ram_lo = nr[0];
                res.ram_hi = nr[WB-1];
                if (withq) begin
                    q_reg     = nq;
                    res.q_lo = nq[0];
                    res.q_hi = nq[WB-1];
                end
            end
        endcase
        return 1'b1;
    endfunction

    task automatic check_field(input string name, input logic [WB-1:0] want,
                               input logic [WB-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            n_mismatch++;
        end
    endtask

    always @(posedge i_clk) begin
        t_alu_result want;
        t_alu_result pred;
        if (!i_rst_n) begin
            foreach (reg_file[k]) reg_file[k] = '0;
            q_reg     = '0;
            link_mode = LINK_ZERO;
            expected_results.delete();
            o_pending <= 0;
        end else begin
            if (i_cfg_wr_en) begin
                link_mode = i_cfg_wr_data;
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result: expected none, actual y=%0h",
                             $time, i_y_out);
                    n_mismatch++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("y_out", want.y, i_y_out);
                    check_field("zero", want.zero, i_zero);
                    check_field("sign", want.sign, i_sign);
                    check_field("carry_out", want.carry, i_carry_out);
                    check_field("overflow", want.ovf, i_overflow);
                    check_field("ram_low_bit", want.ram_lo, i_ram_low_bit);
                    check_field("ram_high_bit", want.ram_hi, i_ram_high_bit);
                    check_field("q_low_bit", want.q_lo, i_q_low_bit);
                    check_field("q_high_bit", want.q_hi, i_q_high_bit);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (exec_microinstr(i_src_select, i_func, i_dest_select, i_addr_a,
                                    i_addr_b, i_data_in, i_carry_in, i_clear, pred)) begin
                    expected_results.push_back(pred);
                end
            end
            o_pending <= expected_results.size();
        end
    end

endmodule

[bench/bit_slice_alu_with_register_file_top_tb.sv]
// ---------------------------------------------------------------------------
// bit_slice_alu_with_register_file_top_tb
// Drives directed and random microinstructions into the bit-slice ALU under
// each shift link mode, with random gaps and stalls, a long output hold-off,
// and a checker beside the block that predicts and compares every result.
// ---------------------------------------------------------------------------
module bit_slice_alu_with_register_file_top_tb;
    import bsalu_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEMS_PER_PHASE = 200;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    t_link                 cfg_wr_data;
    logic                  in_valid;
    t_code                 src_select;
    t_code                 func;
    t_code                 dest_select;
    logic [FIELD_BITS-1:0] addr_a;
    logic [FIELD_BITS-1:0] addr_b;
    logic [FIELD_BITS-1:0] data_in;
    logic                  carry_in;
    logic                  clear;
    logic                  out_stall;

    wire                   in_stall;
    wire                   out_valid;
    wire [FIELD_BITS-1:0]  y_out;
    wire                   zero, sign, carry_out, overflow;
    wire                   ram_low_bit, ram_high_bit, q_low_bit, q_high_bit;
    int                    pending;
    int                    error_count;

    int                    gap_pct   = 0;
    int                    stall_pct = 0;
    bit                    hold_req  = 1'b0;
    t_link                 link_seq [5] = '{LINK_DBL, LINK_ROT, LINK_XROT, LINK_ZERO, LINK_DBL};

    bit_slice_alu_with_register_file_top i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_wr_data  (cfg_wr_data),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_src_select   (src_select),
        .i_func         (func),
        .i_dest_select  (dest_select),
        .i_addr_a       (addr_a),
        .i_addr_b       (addr_b),
        .i_data_in      (data_in),
        .i_carry_in     (carry_in),
        .i_clear        (clear),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_y_out        (y_out),
        .o_zero         (zero),
        .o_sign         (sign),
        .o_carry_out    (carry_out),
        .o_overflow     (overflow),
        .o_ram_low_bit  (ram_low_bit),
        .o_ram_high_bit (ram_high_bit),
        .o_q_low_bit    (q_low_bit),
        .o_q_high_bit   (q_high_bit)
    );

    bit_slice_alu_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_wr_data  (cfg_wr_data),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_src_select   (src_select),
        .i_func         (func),
        .i_dest_select  (dest_select),
        .i_addr_a       (addr_a),
        .i_addr_b       (addr_b),
        .i_data_in      (data_in),
        .i_carry_in     (carry_in),
        .i_clear        (clear),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_y_out        (y_out),
        .i_zero         (zero),
        .i_sign         (sign),
        .i_carry_out    (carry_out),
        .i_overflow     (overflow),
        .i_ram_low_bit  (ram_low_bit),
        .i_ram_high_bit (ram_high_bit),
        .i_q_low_bit    (q_low_bit),
        .i_q_high_bit   (q_high_bit),
        .o_pending      (pending),
        .o_error_count  (error_count)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #(3_000_000);
        $display("DONE: errors detected");
        $finish;
    end

    // result side: short random stalls, plus one long hold-off on request
    initial begin
        out_stall = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (40) @(posedge clk);
                out_stall <= 1'b0;
            end else if ($urandom_range(99) < stall_pct) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 3)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    task automatic send_item(input t_code s, input t_code f, input t_code d,
                             input logic [FIELD_BITS-1:0] a, input logic [FIELD_BITS-1:0] b,
                             input logic [FIELD_BITS-1:0] dat, input logic c,
                             input logic clr);
        if ($urandom_range(99) < gap_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        src_select  <= s;
        func        <= f;
        dest_select <= d;
        addr_a      <= a;
        addr_b      <= b;
        data_in     <= dat;
        carry_in    <= c;
        clear       <= clr;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // stop sending and wait until every predicted result has been taken
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_link_mode(input t_link m);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial begin
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = LINK_ZERO;
        in_valid    = 1'b0;
        src_select  = SRC_AQ;
        func        = FN_ADD;
        dest_select = DST_NOP;
        addr_a      = '0;
        addr_b      = '0;
        data_in     = '0;
        carry_in    = 1'b0;
        clear       = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        gap_pct   = 25;
        stall_pct = 25;
        write_link_mode(LINK_ZERO);
        send_item(SRC_AQ, FN_ADD,   DST_QREG,  4'd0,  4'd0,  4'd0,  1'b0, 1'b1);
        send_item(SRC_DZ, FN_ADD,   DST_RAMF,  4'd0,  4'd15, 4'd15, 1'b0, 1'b0);
        send_item(SRC_DZ, FN_ADD,   DST_QREG,  4'd0,  4'd0,  4'd9,  1'b1, 1'b0);
        send_item(SRC_DZ, FN_ADD,   DST_RAMF,  4'd0,  4'd0,  4'd0,  1'b0, 1'b0);
        send_item(SRC_AB, FN_ADD,   DST_RAMA,  4'd15, 4'd15, 4'd0,  1'b1, 1'b0);
        send_item(SRC_AQ, FN_SUBR,  DST_NOP,   4'd0,  4'd0,  4'd0,  1'b0, 1'b0);
        send_item(SRC_ZQ, FN_SUBS,  DST_QREG,  4'd0,  4'd0,  4'd0,  1'b1, 1'b0);
        send_item(SRC_ZB, FN_OR,    DST_RAMF,  4'd0,  4'd3,  4'd0,  1'b0, 1'b0);
        send_item(SRC_ZA, FN_AND,   DST_NOP,   4'd15, 4'd0,  4'd0,  1'b0, 1'b0);
        send_item(SRC_DA, FN_NOTRS, DST_RAMQD, 4'd15, 4'd1,  4'd5,  1'b0, 1'b0);
        send_item(SRC_DQ, FN_XOR,   DST_RAMD,  4'd0,  4'd2,  4'd15, 1'b1, 1'b0);
        send_item(SRC_DZ, FN_XNOR,  DST_RAMQU, 4'd0,  4'd4,  4'd0,  1'b0, 1'b0);
        send_item(SRC_AB, FN_ADD,   DST_RAMU,  4'd1,  4'd15, 4'd10, 1'b1, 1'b0);
        send_item(SRC_DZ, FN_ADD,   DST_NOP,   4'd0,  4'd0,  4'd7,  1'b1, 1'b0);
        send_item(SRC_DZ, FN_SUBS,  DST_NOP,   4'd0,  4'd0,  4'd8,  1'b0, 1'b0);
        send_item(SRC_DZ, FN_SUBR,  DST_RAMF,  4'd0,  4'd7,  4'd15, 1'b1, 1'b0);
        send_item(SRC_AQ, FN_SUBR,  DST_RAMQD, 4'd15, 4'd15, 4'd3,  1'b0, 1'b0);
        send_item(SRC_AQ, FN_ADD,   DST_NOP,   4'd0,  4'd0,  4'd0,  1'b0, 1'b1);
        send_item(SRC_AB, FN_ADD,   DST_NOP,   4'd15, 4'd15, 4'd0,  1'b0, 1'b0);

        for (int p = 0; p < 5; p++) begin
            write_link_mode(link_seq[p]);
            gap_pct   = (p == 1 || p == 4) ? 0 : 20;
            stall_pct = (p == 2 || p == 4) ? 0 : 20;
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                if (p == 1 && i == 50) begin
                    hold_req = 1'b1;
                end
                send_item(t_code'($urandom_range(7)), t_code'($urandom_range(7)),
                          t_code'($urandom_range(7)), 4'($urandom_range(15)),
                          4'($urandom_range(15)), 4'($urandom_range(15)),
                          1'($urandom_range(1)), ($urandom_range(39) == 0));
            end
        end

        drain_results();
        repeat (6) @(posedge clk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
